// File: rtl/ctcgd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctcgd_pkg
// Shared types and constants of the CTC greedy decoder.
// ----------------------------------------------------------------------------
package ctcgd_pkg;

   // Sizes of the decoder.
   localparam int MAX_CLASSES = 8192;
   localparam int MAX_STEPS   = 1024;
   localparam int SCORE_BITS  = 16;

   localparam int NCLS_BITS   = 14;   // row_classes register
   localparam int IDX_BITS    = 13;   // class index and dictionary size
   localparam int COUNT_BITS  = 11;   // symbols per sequence
   localparam int SUM_BITS    = 27;   // signed score sum
   localparam int DIV_BITS    = 26;   // magnitude of the score sum
   localparam int DIV_CNT_BITS = 5;   // divider step counter
   localparam int RSP_DATA_BITS = 48;
   localparam int CSR_ADDR_BITS = 4;

   // Register map, word addressed.
   typedef enum logic [1:0] {
      REG_ROW_CLASSES = 2'd0,
      REG_DICT_SIZE   = 2'd1,
      REG_USE_SPACE   = 2'd2
   } reg_index_type;

   // Result kinds.
   localparam logic KIND_SYMBOL  = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_SUMMARY
   } state_type;

   // Divider status toward the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// File: rtl/ctcgd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctcgd_div
// Restoring divider, one quotient bit per cycle, for the sequence mean.
// ----------------------------------------------------------------------------
module ctcgd_div
   import ctcgd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [DIV_BITS-1:0]     dividend,
   input  logic [COUNT_BITS-1:0]   divisor,
   output div_stat_type            stat,
   output logic [DIV_BITS-1:0]     quotient
);

   logic [COUNT_BITS-1:0]   rem_ff, rem_in;
   logic [DIV_BITS-1:0]     shift_ff, shift_in;
   logic [COUNT_BITS-1:0]   divisor_ff, divisor_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    done_ff, done_in;
   logic [COUNT_BITS:0]     trial;
   logic                    fits;

   // One compare and subtract per cycle; the quotient bits shift in at the bottom.
   always_comb begin
      trial      = {rem_ff, shift_ff[DIV_BITS-1]};
      fits       = trial >= {1'b0, divisor_ff};
      rem_in     = rem_ff;
      shift_in   = shift_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      done_in    = 1'b0;
      if (start) begin
         rem_in     = '0;
         shift_in   = dividend;
         divisor_in = divisor;
         cnt_in     = DIV_CNT_BITS'(DIV_BITS);
      end else if (cnt_ff != '0) begin
         rem_in   = fits ? COUNT_BITS'(trial - {1'b0, divisor_ff}) : trial[COUNT_BITS-1:0];
         shift_in = {shift_ff[DIV_BITS-2:0], fits};
         cnt_in   = cnt_ff - 1'b1;
         done_in  = (cnt_ff == DIV_CNT_BITS'(1));
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      shift_ff   <= shift_in;
      divisor_ff <= divisor_in;
   end

   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;
   assign quotient  = shift_ff;

endmodule

// File: rtl/ctc_greedy_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctc_greedy_decoder_top
// CTC greedy decoder over a stream of fixed-point class scores.
// ----------------------------------------------------------------------------
// Scores enter on the req_ stream, one signed Q2.14 class score per
// transaction, row_classes transactions per timestep row; req_tlast marks the
// last row of a sequence and is looked at on the last score of each row.
// The rsp_ stream returns decoded symbols (tuser low) and, after the last
// row, one summary with the mean score and symbol count (tuser and tlast high).
// The user must see that registers are written through the csr_ APB port
// while the block is idle; the block itself does not enforce this. A score
// is taken each cycle inside a row. The last score of a row leads to the
// collapse decision, which loads a symbol into the output register. For the
// final row a restoring divider then forms the mean, one quotient bit per
// cycle over 26 bits. req_tready is low outside the idle state.
// The output register holds a result until taken; a stalled receiver holds the
// sequencer at its next result and so back-pressures the score stream.
// Reset clears the sequence state and restores the register defaults.
// ----------------------------------------------------------------------------
module ctc_greedy_decoder_top
   import ctcgd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // Score stream
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [15:0]                req_tdata,   // [15:0] class_score
   input  logic                       req_tlast,   // final_step
   // Result stream
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // [12:0] dict_entry, [13] is_space, [29:14] mean_score,
   // [40:30] symbol_count, [47:41] zero
   output logic [RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic                       rsp_tuser,   // result_kind
   output logic                       rsp_tlast,   // last
   // Configuration port
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   // Configuration registers
   logic [NCLS_BITS-1:0]  row_classes_ff;
   logic [IDX_BITS-1:0]   dict_size_ff;
   logic                  use_space_ff;
   reg_index_type         csr_index;
   logic                  csr_write;

   // Sequencer and sequence state
   state_type               state_ff, state_in;
   logic [IDX_BITS-1:0]     pos_ff, pos_in;
   logic signed [SCORE_BITS-1:0] best_val_ff, best_val_in;
   logic [IDX_BITS-1:0]     best_idx_ff, best_idx_in;
   logic                    final_ff, final_in;
   logic [IDX_BITS-1:0]     prev_win_ff, prev_win_in;
   logic                    prev_valid_ff, prev_valid_in;
   logic signed [SUM_BITS-1:0] sum_ff, sum_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;

   // Output register
   logic                    out_valid_ff, out_valid_in;
   logic                    out_kind_ff, out_kind_in;
   logic [IDX_BITS-1:0]     out_entry_ff, out_entry_in;
   logic                    out_space_ff, out_space_in;
   logic [SCORE_BITS-1:0]   out_mean_ff, out_mean_in;
   logic [COUNT_BITS-1:0]   out_count_ff, out_count_in;

   // Working signals
   logic [NCLS_BITS-1:0]    n_eff;
   logic signed [SCORE_BITS-1:0] score;
   logic                    take;
   logic                    row_end;
   logic                    out_free;
   logic                    emit_entry;
   logic                    emit_space;
   logic                    div_start;
   logic [DIV_BITS-1:0]     sum_mag;
   logic [DIV_BITS-1:0]     quotient;
   logic [SCORE_BITS-1:0]   q_low;
   div_stat_type            div_stat;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_classes_ff <= NCLS_BITS'(2);
         dict_size_ff   <= '0;
         use_space_ff   <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            REG_ROW_CLASSES: row_classes_ff <= csr_pwdata[NCLS_BITS-1:0];
            REG_DICT_SIZE:   dict_size_ff   <= csr_pwdata[IDX_BITS-1:0];
            REG_USE_SPACE:   use_space_ff   <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_ROW_CLASSES: csr_prdata = 32'(row_classes_ff);
         REG_DICT_SIZE:   csr_prdata = 32'(dict_size_ff);
         REG_USE_SPACE:   csr_prdata = 32'(use_space_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // Class count limited to the supported range.
   always_comb begin
      if (row_classes_ff < NCLS_BITS'(2)) begin
         n_eff = NCLS_BITS'(2);
      end else if (row_classes_ff > NCLS_BITS'(MAX_CLASSES)) begin
         n_eff = NCLS_BITS'(MAX_CLASSES);
      end else begin
         n_eff = row_classes_ff;
      end
   end

   // Running arg-max; a later score wins only when strictly greater.
   assign score   = signed'(req_tdata);
   assign take    = (pos_ff == '0) || (score > best_val_ff);
   assign row_end = ({1'b0, pos_ff} + NCLS_BITS'(1)) >= n_eff;

   // Collapse and mapping of the row winner.
   assign emit_entry = (best_idx_ff <= dict_size_ff);
   assign emit_space = use_space_ff &&
                       ({1'b0, best_idx_ff} == ({1'b0, dict_size_ff} + NCLS_BITS'(1)));

   assign out_free = !out_valid_ff || rsp_tready;

   // Mean by the divider on magnitudes, sign applied afterward.
   assign sum_mag = sum_ff[SUM_BITS-1] ? DIV_BITS'(-sum_ff) : DIV_BITS'(sum_ff);
   assign q_low   = quotient[SCORE_BITS-1:0];

   ctcgd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_mag),
      .divisor  (count_ff),
      .stat     (div_stat),
      .quotient (quotient)
   );

   // Sequencer: next state, state updates and result loading.
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      best_val_in   = best_val_ff;
      best_idx_in   = best_idx_ff;
      final_in      = final_ff;
      prev_win_in   = prev_win_ff;
      prev_valid_in = prev_valid_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_kind_in   = out_kind_ff;
      out_entry_in  = out_entry_ff;
      out_space_in  = out_space_ff;
      out_mean_in   = out_mean_ff;
      out_count_in  = out_count_ff;
      req_tready    = 1'b0;
      div_start     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (take) begin
                  best_val_in = score;
                  best_idx_in = pos_ff;
               end
               if (row_end) begin
                  pos_in   = '0;
                  final_in = req_tlast;
                  state_in = ST_DECIDE;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               if (best_idx_ff == '0) begin
                  prev_win_in   = '0;
                  prev_valid_in = 1'b1;
               end else begin
                  if (!(prev_valid_ff && (best_idx_ff == prev_win_ff)) &&
                      (emit_entry || emit_space)) begin
                     out_valid_in = 1'b1;
                     out_kind_in  = KIND_SYMBOL;
                     out_entry_in = emit_entry ? (best_idx_ff - 1'b1) : '0;
                     out_space_in = !emit_entry;
                     out_mean_in  = '0;
                     out_count_in = '0;
                     if (count_ff < COUNT_BITS'(MAX_STEPS)) begin
                        sum_in   = sum_ff + SUM_BITS'(best_val_ff);
                        count_in = count_ff + 1'b1;
                     end
                  end
                  prev_win_in   = best_idx_ff;
                  prev_valid_in = 1'b1;
               end
               state_in = final_ff ? ST_DIV_START : ST_IDLE;
            end
         end
         ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_stat.done) begin
               state_in = ST_SUMMARY;
            end
         end
         ST_SUMMARY: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = KIND_SUMMARY;
               out_entry_in = '0;
               out_space_in = 1'b0;
               if (count_ff == '0) begin
                  out_mean_in = '0;
               end else if (sum_ff[SUM_BITS-1]) begin
                  out_mean_in = -q_low;
               end else begin
                  out_mean_in = q_low;
               end
               out_count_in  = count_ff;
               prev_win_in   = '0;
               prev_valid_in = 1'b0;
               sum_in        = '0;
               count_in      = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pos_ff        <= '0;
         prev_win_ff   <= '0;
         prev_valid_ff <= 1'b0;
         sum_ff        <= '0;
         count_ff      <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         prev_win_ff   <= prev_win_in;
         prev_valid_ff <= prev_valid_in;
         sum_ff        <= sum_in;
         count_ff      <= count_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload.
   always_ff @(posedge clock) begin
      best_val_ff  <= best_val_in;
      best_idx_ff  <= best_idx_in;
      final_ff     <= final_in;
      out_kind_ff  <= out_kind_in;
      out_entry_ff <= out_entry_in;
      out_space_ff <= out_space_in;
      out_mean_ff  <= out_mean_in;
      out_count_ff <= out_count_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_count_ff, out_mean_ff, out_space_ff, out_entry_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = (out_kind_ff == KIND_SUMMARY);

endmodule

// File: rtl/ctcgd_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctcgd_chk
// Port-level checks of the CTC greedy decoder result stream.
// ----------------------------------------------------------------------------
module ctcgd_chk
   import ctcgd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [15:0]                req_tdata,
   input  logic                       req_tlast,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                       rsp_tuser,
   input  logic                       rsp_tlast,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [31:0]                csr_pwdata,
   input  logic [31:0]                csr_prdata,
   input  logic                       csr_pready
);

   // A stalled result transaction keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // Only the summary closes a sequence.
   a_last_is_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == rsp_tuser))
      else $error("tlast does not match the summary kind");

   // A symbol carries neither mean nor count, and a space has no entry.
   a_symbol_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (rsp_tdata[40:14] == '0) &&
         (!rsp_tdata[13] || (rsp_tdata[12:0] == '0)))
      else $error("symbol carries summary fields");

   // The summary count never passes the step limit, and a summary has no entry or space.
   a_summary_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata[40:30] <= COUNT_BITS'(MAX_STEPS)) &&
         (rsp_tdata[13:0] == '0))
      else $error("summary count out of range");

endmodule

bind ctc_greedy_decoder_top ctcgd_chk u_ctcgd_chk (.*);

// File: tb/ctc_greedy_decoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctc_greedy_decoder_top_tb
// Self-checking testbench for the CTC greedy decoder.
// ----------------------------------------------------------------------------
// Score rows are streamed into the decoder while a tracker object follows
// the arg-max, blank, collapse and dictionary mapping of every row. It also
// follows the running score sum. The tracker queues the symbols and
// end-of-sequence summaries that each accepted score should produce.
// Every result taken from the output stream is compared field by field with
// the oldest queued expectation.
// The run starts with a handful of hand-built rows, including a class count
// below the minimum and a width change in the middle of a row. Then random
// sequences run under three idling patterns, with one long receiver stall
// and sender pauses until every result has arrived, one of them forced.
// Registers are only written while the decoder is idle and are read back.
// ----------------------------------------------------------------------------
module ctc_greedy_decoder_top_tb;
   import ctcgd_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 40;     // covers the decision and divider
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_SCORES = 1470;
   localparam int PRINT_LIMIT   = 40;

   // One result of the decoder, split into its fields.
   typedef struct packed {
      logic                  kind;
      logic [IDX_BITS-1:0]   entry;
      logic                  space;
      logic [SCORE_BITS-1:0] mean;
      logic [COUNT_BITS-1:0] count;
      logic                  last;
   } decoded_result_type;

   // Follows the decoder state and holds the results it still owes.
   class score_decode_tracker;
      logic [NCLS_BITS-1:0]         row_classes_q;
      logic [IDX_BITS-1:0]          dict_size_q;
      logic                         use_space_q;
      logic [IDX_BITS-1:0]          column;
      logic signed [SCORE_BITS-1:0] best_score;
      logic [IDX_BITS-1:0]          best_class;
      logic [IDX_BITS-1:0]          prev_class;
      logic                         prev_seen;
      logic signed [SUM_BITS-1:0]   score_total;
      logic [COUNT_BITS-1:0]        symbols;
      decoded_result_type           awaited[$];
      int                           mismatches;

      function new();
         row_classes_q = NCLS_BITS'(2);
         dict_size_q   = '0;
         use_space_q   = 1'b0;
         column        = '0;
         best_score    = '0;
         best_class    = '0;
         prev_class    = '0;
         prev_seen     = 1'b0;
         score_total   = '0;
         symbols       = '0;
         mismatches    = 0;
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, what);
      endtask

      function void write_reg(reg_index_type idx, logic [31:0] value);
         case (idx)
            REG_ROW_CLASSES: row_classes_q = value[NCLS_BITS-1:0];
            REG_DICT_SIZE:   dict_size_q   = value[IDX_BITS-1:0];
            REG_USE_SPACE:   use_space_q   = value[0];
            default: ;
         endcase
      endfunction

      function logic [31:0] reg_value(reg_index_type idx);
         case (idx)
            REG_ROW_CLASSES: return 32'(row_classes_q);
            REG_DICT_SIZE:   return 32'(dict_size_q);
            REG_USE_SPACE:   return 32'(use_space_q);
            default:         return '0;
         endcase
      endfunction

      // Effective row width after clamping the register to its legal range.
      function int row_length();
         if (row_classes_q < 2) return 2;
         if (row_classes_q > MAX_CLASSES) return MAX_CLASSES;
         return int'(row_classes_q);
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      // Accepted score: update the row search and queue what the row yields.
      function void note_score(logic [SCORE_BITS-1:0] raw, logic final_row);
         logic signed [SCORE_BITS-1:0] score;
         decoded_result_type r;
         logic hit;
         int quotient;
         score = raw;
         hit   = 1'b0;
         if (column == 0) begin
            best_score = score;
            best_class = '0;
         end else if (score > best_score) begin
            best_score = score;
            best_class = column;
         end
         // A row ends once the position reaches the current width minus one.
         if (int'(column) + 1 < row_length()) begin
            column++;
            return;
         end
         column = '0;

         // Blank and repeated winners emit nothing; others map to a symbol.
         if (best_class != 0 && !(prev_seen && best_class == prev_class)) begin
            r = '0;
            if (int'(best_class) <= int'(dict_size_q)) begin
               hit     = 1'b1;
               r.entry = best_class - 1'b1;
            end else if (use_space_q && int'(best_class) == int'(dict_size_q) + 1) begin
               hit     = 1'b1;
               r.space = 1'b1;
            end
            if (hit) begin
               r.kind = KIND_SYMBOL;
               awaited.push_back(r);
               // The mean only covers the first MAX_STEPS symbols.
               if (symbols < MAX_STEPS) begin
                  score_total += best_score;
                  symbols++;
               end
            end
         end
         prev_class = best_class;
         prev_seen  = 1'b1;

         // The last row of a sequence closes it with a summary.
         if (final_row) begin
            r      = '0;
            r.kind = KIND_SUMMARY;
            if (symbols != 0) begin
               quotient = int'(score_total) / int'(symbols);
               r.mean   = quotient[SCORE_BITS-1:0];
            end
            r.count = symbols;
            r.last  = 1'b1;
            awaited.push_back(r);
            prev_class  = '0;
            prev_seen   = 1'b0;
            score_total = '0;
            symbols     = '0;
         end
      endfunction

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
      endtask

      task check_result(decoded_result_type got);
         decoded_result_type want;
         if (awaited.size() == 0) begin
            report_mismatch("result arrived with nothing expected");
            return;
         end
         want = awaited.pop_front();
         compare_field("result_kind", 32'(got.kind), 32'(want.kind));
         compare_field("dict_entry", 32'(got.entry), 32'(want.entry));
         compare_field("is_space", 32'(got.space), 32'(want.space));
         compare_field("mean_score", 32'(got.mean), 32'(want.mean));
         compare_field("symbol_count", 32'(got.count), 32'(want.count));
         compare_field("last", 32'(got.last), 32'(want.last));
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [15:0]              req_tdata = '0;   // [15:0] class_score
   logic                     req_tlast = 1'b0; // final_step
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // [12:0] dict_entry, [13] is_space, [29:14] mean_score,
   // [40:30] symbol_count, [47:41] zero
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tuser;        // result_kind
   logic                     rsp_tlast;        // last
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [31:0]              csr_pwdata = '0;
   logic [31:0]              csr_prdata;
   logic                     csr_pready;

   score_decode_tracker tracker = new();
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_requests = 0;
   int          hold_seen = 0;
   int          hold_left = 0;
   int          sent_scores = 0;
   bit          pause_pending = 1'b0;
   int unsigned cycle_count = 0;

   ctc_greedy_decoder_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Result side: check each transaction, then choose the next tready.
   always @(posedge clock) begin
      decoded_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind  = rsp_tuser;
         got.entry = rsp_tdata[12:0];
         got.space = rsp_tdata[13];
         got.mean  = rsp_tdata[29:14];
         got.count = rsp_tdata[40:30];
         got.last  = rsp_tlast;
         tracker.check_result(got);
      end
      if (hold_seen != hold_requests) begin
         hold_seen  <= hold_requests;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offer one score, idling first at random, and wait for the transaction.
   task automatic send_score(logic [15:0] score, logic final_row);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= score;
      req_tlast  <= final_row;
      do @(posedge clock); while (!req_tready);
      tracker.note_score(score, final_row);
      sent_scores++;
   endtask

   // Stop offering and wait until every expected result has been taken.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
   endtask

   // Drain, then give a row that produced nothing time to finish.
   task automatic wait_idle();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write followed by a read-back, both through the APB port.
   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.write_reg(idx, value);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== tracker.reg_value(idx))
         tracker.report_mismatch($sformatf("register %s reads 0x%0h, expected 0x%0h",
                                           idx.name(), csr_prdata, tracker.reg_value(idx)));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // One row at the current width. Style 0 plants top at class winner so
   // that it is the first maximum; style 1 is full-range noise and style 2
   // draws from a narrow range full of ties. The final flag of every score
   // but the last is random, since the block ignores it there.
   task automatic send_row(int winner, int top, logic final_row, int style);
      int width;
      logic [15:0] score;
      width = tracker.row_length();
      for (int i = 0; i < width; i++) begin
         if (style == 1)
            score = 16'($urandom_range(0, 65535));
         else if (style == 2)
            score = 16'(int'($urandom_range(0, 2)) - 1);
         else if (i == winner)
            score = 16'(top);
         else if (i < winner)
            score = 16'(int'($urandom_range(0, top + 32767)) - 32768);
         else
            score = 16'(int'($urandom_range(0, top + 32768)) - 32768);
         send_score(score, (i == width - 1) ? final_row : 1'($urandom_range(1)));
      end
   endtask

   task automatic send_four(int a, int b, int c, int d, logic final_row);
      send_score(16'(a), 1'b0);
      send_score(16'(b), 1'b0);
      send_score(16'(c), 1'b0);
      send_score(16'(d), final_row);
   endtask

   // A random sequence of rows, mostly with planted winners that often
   // repeat, hit blank or land on the space class.
   task automatic run_sequence();
      int rows;
      int width;
      int winner;
      int prev_winner;
      int top;
      int style;
      rows = $urandom_range(1, 8);
      prev_winner = 0;
      for (int r = 0; r < rows; r++) begin
         if (r > 0 && (pause_pending || $urandom_range(24) == 0)) begin
            pause_pending = 1'b0;
            drain();
         end
         width = tracker.row_length();
         case ($urandom_range(9))
            0, 1, 2, 3: winner = prev_winner;
            4:          winner = 0;
            5:          winner = int'(tracker.dict_size_q) + 1;
            default:    winner = $urandom_range(0, width - 1);
         endcase
         if (winner >= width) winner = width - 1;
         prev_winner = winner;
         top = int'($urandom_range(1, 65535)) - 32768;
         style = ($urandom_range(9) < 8) ? 0 : int'($urandom_range(1, 2));
         send_row(winner, top, r == rows - 1, style);
      end
   endtask

   initial begin
      int phase_start;
      int width;
      logic [31:0] filler;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Hand-built rows: classes 1 and 2 are entries, class 3 is the space.
      send_idle_pct = 26;
      recv_idle_pct = 52;
      csr_write(REG_ROW_CLASSES, 32'd4);
      csr_write(REG_DICT_SIZE, 32'd2);
      csr_write(REG_USE_SPACE, 32'd1);
      send_four(-32768, 32767, 0, 5, 1'b0);          // entry 0
      send_four(0, 32767, 32767, -1, 1'b0);          // tie, first wins, collapsed
      send_four(100, -5, -5, 100, 1'b0);             // tie on blank
      send_four(-1, -2, -3, 200, 1'b0);              // space
      send_four(-32768, -32768, -32767, -32768, 1'b1); // entry 1, then summary

      // A width below the minimum acts as two; the winner maps to nothing.
      wait_idle();
      csr_write(REG_ROW_CLASSES, 32'd1);
      csr_write(REG_DICT_SIZE, 32'd0);
      csr_write(REG_USE_SPACE, 32'd0);
      send_score(16'd0, 1'b0);
      send_score(16'd1, 1'b1);                       // skipped, empty summary

      // Shrink the width in the middle of a row.
      wait_idle();
      csr_write(REG_ROW_CLASSES, 32'd6);
      csr_write(REG_DICT_SIZE, 32'd2);
      csr_write(REG_USE_SPACE, 32'd1);
      send_score(16'(-7), 1'b0);
      send_score(16'd3, 1'b1);
      send_score(16'(-2), 1'b0);
      wait_idle();
      csr_write(REG_ROW_CLASSES, 32'd2);
      send_score(16'd9, 1'b1);                       // row ends here on a space

      // Random sequences under each idling pattern.
      for (int m = 0; m < 3; m++) begin
         send_idle_pct = (m == 0) ? 26 : (m == 1) ? 52 : 0;
         recv_idle_pct = (m == 0) ? 52 : (m == 1) ? 26 : 0;
         pause_pending = (m == 1);
         phase_start   = sent_scores;
         while (sent_scores - phase_start < RANDOM_SCORES / 3) begin
            wait_idle();
            width = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            filler = $urandom;
            csr_write(REG_ROW_CLASSES, {filler[31:NCLS_BITS], NCLS_BITS'(width)});
            case ($urandom_range(5))
               0:       csr_write(REG_DICT_SIZE, 32'd0);
               1:       csr_write(REG_DICT_SIZE, 32'h1FFF);
               2:       csr_write(REG_DICT_SIZE, $urandom);
               default: csr_write(REG_DICT_SIZE, 32'($urandom_range(0, width)));
            endcase
            csr_write(REG_USE_SPACE, $urandom);
            // A long receiver stall while scores keep coming.
            if (m == 0 && sent_scores == phase_start)
               hold_requests <= hold_requests + 1;
            repeat ($urandom_range(1, 3)) run_sequence();
         end
      end

      wait_idle();
      if (tracker.mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
